// ===== src/awg_pkg.sv =====
`timescale 1ns / 1ps

package awg_pkg;

   // Field widths of the request, response and configuration ports, and of internal datapath values.
   localparam int unsigned REQ_W        = 2;
   localparam int unsigned HN_W         = 9;
   localparam int unsigned AMP_W        = 16;
   localparam int unsigned IDX_W        = 10;
   localparam int unsigned SAMPLE_W     = 16;
   localparam int unsigned PEAK_OUT_W   = 38;
   localparam int unsigned PEAK_W       = 39;
   localparam int unsigned RAW_W        = 40;
   localparam int unsigned STATUS_W     = 2;
   localparam int unsigned PHASE_W      = 16;
   localparam int unsigned PROD_W       = 32;

   // Default sizes handed to the top level parameters.
   localparam int unsigned TABLE_SIZE_DEFAULT    = 1024;
   localparam int unsigned MAX_HARMONICS_DEFAULT = 256;

   // Polynomial sine coefficients, all Q2.14.
   localparam int unsigned SIN_A = 25736;
   localparam int unsigned SIN_B = 10512;
   localparam int unsigned SIN_C = 1160;
   localparam int unsigned QUARTER = 16384;

   // Quotient bits produced by the normalizing divider.
   localparam int unsigned DIV_STEPS = 15;

   typedef enum logic [REQ_W-1:0] {
      REQ_LOAD = 2'd0,
      REQ_GEN  = 2'd1,
      REQ_READ = 2'd2,
      REQ_NOP  = 2'd3
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_PEAK_ZERO = 2'd1,
      ST_RANGE     = 2'd2,
      ST_UNUSED    = 2'd3
   } status_code_type;

   typedef struct packed {
      logic capture;
      logic load_we;
      logic gen_init;
      logic gen_issue;
      logic rd_mod_step;
      logic rd_fetch;
      logic div_init;
      logic div_step;
      logic respond;
   } ctrl_cmd_type;

   typedef struct packed {
      logic issue_last;
      logic pipe_empty;
      logic idx_in_range;
      logic div_done;
   } dp_stat_type;

endpackage

// ===== src/awg_ctrl.sv =====
`timescale 1ns / 1ps

module awg_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [awg_pkg::REQ_W-1:0]   req_type,
   input  awg_pkg::dp_stat_type        stat,
   output logic                        busy,
   output awg_pkg::ctrl_cmd_type       cmd
);
   import awg_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE      = 9'b000000001,
      S_LOAD      = 9'b000000010,
      S_GEN_INIT  = 9'b000000100,
      S_GEN_RUN   = 9'b000001000,
      S_GEN_DRAIN = 9'b000010000,
      S_RD_MOD    = 9'b000100000,
      S_RD_PREP   = 9'b001000000,
      S_RD_DIV    = 9'b010000000,
      S_RESP      = 9'b100000000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               unique case (req_kind_type'(req_type))
                  REQ_LOAD: state_in = S_LOAD;
                  REQ_GEN:  state_in = S_GEN_INIT;
                  REQ_READ: state_in = S_RD_MOD;
                  default:  state_in = S_RESP;
               endcase
            end
         end
         S_LOAD: begin
            cmd.load_we = 1'b1;
            state_in    = S_RESP;
         end
         S_GEN_INIT: begin
            cmd.gen_init = 1'b1;
            state_in     = S_GEN_RUN;
         end
         S_GEN_RUN: begin
            cmd.gen_issue = 1'b1;
            if (stat.issue_last) begin
               state_in = S_GEN_DRAIN;
            end
         end
         S_GEN_DRAIN: begin
            if (stat.pipe_empty) begin
               state_in = S_RESP;
            end
         end
         S_RD_MOD: begin
            if (stat.idx_in_range) begin
               cmd.rd_fetch = 1'b1;
               state_in     = S_RD_PREP;
            end else begin
               cmd.rd_mod_step = 1'b1;
            end
         end
         S_RD_PREP: begin
            cmd.div_init = 1'b1;
            state_in     = S_RD_DIV;
         end
         S_RD_DIV: begin
            if (stat.div_done) begin
               state_in = S_RESP;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_RESP: begin
            cmd.respond = 1'b1;
            state_in    = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/awg_datapath.sv =====
`timescale 1ns / 1ps

module awg_datapath #(
   parameter int unsigned TABLE_SIZE    = awg_pkg::TABLE_SIZE_DEFAULT,
   parameter int unsigned MAX_HARMONICS = awg_pkg::MAX_HARMONICS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  awg_pkg::ctrl_cmd_type                cmd,
   output awg_pkg::dp_stat_type                 stat,
   input  logic                                 csr_we,
   input  logic [awg_pkg::HN_W-1:0]             csr_data,
   input  logic [awg_pkg::REQ_W-1:0]            req_type,
   input  logic [awg_pkg::HN_W-1:0]             req_harmonic_number,
   input  logic signed [awg_pkg::AMP_W-1:0]     req_amplitude_value,
   input  logic [awg_pkg::IDX_W-1:0]            req_sample_index,
   output logic                                 rsp_valid,
   output logic signed [awg_pkg::SAMPLE_W-1:0]  rsp_sample_value,
   output logic [awg_pkg::PEAK_OUT_W-1:0]       rsp_peak_magnitude,
   output logic [awg_pkg::STATUS_W-1:0]         rsp_status
);
   import awg_pkg::*;

   localparam int unsigned TAW    = $clog2(TABLE_SIZE);
   localparam int unsigned HW     = $clog2(MAX_HARMONICS + 1);
   localparam int unsigned AAW    = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
   localparam int unsigned CW     = (HW > HN_W) ? HW : HN_W;
   localparam int unsigned IXW    = ((TAW + 1) > IDX_W) ? (TAW + 1) : IDX_W;
   localparam int unsigned STEP_Q = 65536 / TABLE_SIZE;
   localparam int unsigned STEP_R = 65536 % TABLE_SIZE;
   localparam int unsigned NSTAGE = 7;

   typedef struct packed {
      logic           first;
      logic           last;
      logic           zero;
      logic [TAW-1:0] idx;
   } tag_type;

   // Configuration and captured request.
   logic [HN_W-1:0]         hcount_ff;
   logic [REQ_W-1:0]        kind_ff;
   logic [HN_W-1:0]         hn_ff;
   logic signed [AMP_W-1:0] amp_ff;
   logic [IDX_W-1:0]        idx_ff;

   // Memories.
   logic signed [AMP_W-1:0] amp_mem [MAX_HARMONICS];
   logic signed [RAW_W-1:0] raw_mem [TABLE_SIZE];
   logic signed [AMP_W-1:0] amp_rd_ff;
   logic signed [RAW_W-1:0] rd_data_ff;

   // Issue counters and phase accumulators.
   logic [HW-1:0]      n_ff, k_ff;
   logic [TAW-1:0]     i_ff;
   logic [PHASE_W-1:0] ang_i_ff, ang_p_ff;
   logic [TAW-1:0]     rem_i_ff, rem_p_ff;
   logic [PHASE_W-1:0] ang_i_in, ang_p_in;
   logic [TAW-1:0]     rem_i_in, rem_p_in;
   logic [TAW:0]       rem_sum_i, rem_sum_p;
   logic               carry_i, carry_p;
   logic               last_k, last_i;

   // Sine and accumulate pipeline.
   logic [NSTAGE:1]    v_ff;
   tag_type            tag_ff [NSTAGE:1];
   tag_type            tag_issue;
   logic [PHASE_W-1:0] ang1_ff;
   logic [1:0]         q2_ff, q3_ff, q4_ff;
   logic [14:0]        x2_ff, x3_ff, x4_ff;
   logic [14:0]        sq2_ff, sq3_ff;
   logic signed [AMP_W-1:0] amp2_ff, amp3_ff, amp4_ff, amp5_ff;
   logic [13:0]        t3_ff;
   logic [14:0]        u4_ff;
   logic signed [SAMPLE_W-1:0] sine5_ff;
   logic signed [PROD_W-1:0]   prod6_ff;
   logic signed [RAW_W-1:0]    acc_ff;
   logic [PEAK_W-1:0]          peak_ff;

   logic [13:0] f1;
   logic [14:0] x1;
   logic [29:0] xx1;
   logic [24:0] mt2;
   logic [27:0] mu3;
   logic [29:0] ms4;
   logic [15:0] s4, v4;
   logic signed [SAMPLE_W-1:0] sine4;
   logic [RAW_W-1:0] mag7;

   // Read and divide.
   logic [IXW-1:0]    ix_ext;
   logic              sign_ff, sat_ff;
   logic [RAW_W-1:0]  rem_ff;
   logic [DIV_STEPS-1:0] quo_ff;
   logic [3:0]        cnt_ff;
   logic [RAW_W-1:0]  mag_rd;
   logic [RAW_W:0]    r2;
   logic [RAW_W:0]    pk_ext;

   logic [CW-1:0]     hn_ext, hc_ext;
   logic              hn_valid;

   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff;
   logic [PEAK_OUT_W-1:0]      rsp_peak_ff;
   logic [STATUS_W-1:0]        rsp_status_ff;
   logic signed [SAMPLE_W-1:0] rd_sample;
   logic [SAMPLE_W-1:0]        qv;

   assign hn_ext   = CW'(hn_ff);
   assign hc_ext   = CW'(hcount_ff);
   assign hn_valid = (hn_ext != '0) && (hn_ext <= CW'(MAX_HARMONICS));
   assign ix_ext   = IXW'(idx_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         hcount_ff <= '0;
      end else if (csr_we) begin
         hcount_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_type;
         hn_ff   <= req_harmonic_number;
         amp_ff  <= req_amplitude_value;
         idx_ff  <= req_sample_index;
      end else if (cmd.rd_mod_step) begin
         idx_ff <= IDX_W'(ix_ext - IXW'(TABLE_SIZE));
      end
   end

   // Phase stepping: p = k*i mod TABLE_SIZE is kept as a 16-bit angle plus a
   // remainder in units of 1/TABLE_SIZE, so no division is needed.
   assign rem_sum_i = {1'b0, rem_i_ff} + (TAW+1)'(STEP_R);
   assign carry_i   = (rem_sum_i >= (TAW+1)'(TABLE_SIZE));
   assign rem_i_in  = carry_i ? TAW'(rem_sum_i - (TAW+1)'(TABLE_SIZE)) : TAW'(rem_sum_i);
   assign ang_i_in  = ang_i_ff + PHASE_W'(STEP_Q) + PHASE_W'(carry_i);

   assign rem_sum_p = {1'b0, rem_p_ff} + {1'b0, rem_i_ff};
   assign carry_p   = (rem_sum_p >= (TAW+1)'(TABLE_SIZE));
   assign rem_p_in  = carry_p ? TAW'(rem_sum_p - (TAW+1)'(TABLE_SIZE)) : TAW'(rem_sum_p);
   assign ang_p_in  = ang_p_ff + ang_i_ff + PHASE_W'(carry_p);

   assign last_k = (n_ff == '0) || (k_ff == n_ff);
   assign last_i = (i_ff == TAW'(TABLE_SIZE - 1));

   always_ff @(posedge clock) begin
      if (cmd.gen_init) begin
         n_ff     <= (hc_ext > CW'(MAX_HARMONICS)) ? HW'(MAX_HARMONICS) : HW'(hc_ext);
         k_ff     <= HW'(1);
         i_ff     <= '0;
         ang_i_ff <= '0;
         rem_i_ff <= '0;
         ang_p_ff <= '0;
         rem_p_ff <= '0;
      end else if (cmd.gen_issue) begin
         if (last_k) begin
            k_ff     <= HW'(1);
            i_ff     <= i_ff + TAW'(1);
            ang_i_ff <= ang_i_in;
            rem_i_ff <= rem_i_in;
            ang_p_ff <= ang_i_in;
            rem_p_ff <= rem_i_in;
         end else begin
            k_ff     <= k_ff + HW'(1);
            ang_p_ff <= ang_p_in;
            rem_p_ff <= rem_p_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_we && hn_valid) begin
         amp_mem[AAW'(hn_ext - CW'(1))] <= amp_ff;
      end
      if (cmd.gen_issue) begin
         amp_rd_ff <= amp_mem[AAW'(k_ff - HW'(1))];
      end
   end

   assign tag_issue.first = (k_ff == HW'(1));
   assign tag_issue.last  = last_k;
   assign tag_issue.zero  = (n_ff == '0);
   assign tag_issue.idx   = i_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[NSTAGE-1:1], cmd.gen_issue};
      end
   end

   always_ff @(posedge clock) begin
      tag_ff[1] <= tag_issue;
      for (int s = 2; s <= NSTAGE; s++) begin
         tag_ff[s] <= tag_ff[s-1];
      end
   end

   // Quarter-wave polynomial sine, one multiply per stage.
   assign f1  = ang1_ff[13:0];
   assign x1  = ang1_ff[14] ? 15'(QUARTER - 32'(f1)) : 15'(f1);
   assign xx1 = 30'(x1) * 30'(x1);
   assign mt2 = 25'(sq2_ff) * 25'(SIN_C);
   assign mu3 = 28'(sq3_ff) * 28'(t3_ff);
   assign ms4 = 30'(x4_ff) * 30'(u4_ff);
   assign s4  = 16'(ms4 >> 14);
   assign v4  = (s4 > 16'd16383) ? 16'd32767 : {s4[14:0], 1'b0};
   assign sine4 = q4_ff[1] ? -$signed(v4) : $signed(v4);

   always_ff @(posedge clock) begin
      ang1_ff  <= ang_p_ff;
      q2_ff    <= ang1_ff[15:14];
      x2_ff    <= x1;
      sq2_ff   <= 15'(xx1 >> 14);
      amp2_ff  <= amp_rd_ff;
      q3_ff    <= q2_ff;
      x3_ff    <= x2_ff;
      sq3_ff   <= sq2_ff;
      amp3_ff  <= amp2_ff;
      t3_ff    <= 14'(SIN_B - 32'(mt2 >> 14));
      q4_ff    <= q3_ff;
      x4_ff    <= x3_ff;
      amp4_ff  <= amp3_ff;
      u4_ff    <= 15'(SIN_A - 32'(mu3 >> 14));
      sine5_ff <= sine4;
      amp5_ff  <= amp4_ff;
      prod6_ff <= tag_ff[5].zero ? '0 : PROD_W'(amp5_ff) * PROD_W'(sine5_ff);
   end

   always_ff @(posedge clock) begin
      if (v_ff[6]) begin
         acc_ff <= (tag_ff[6].first ? '0 : acc_ff) + RAW_W'(prod6_ff);
      end
   end

   assign mag7 = acc_ff[RAW_W-1] ? RAW_W'(-acc_ff) : RAW_W'(acc_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff <= '0;
      end else if (cmd.gen_init) begin
         peak_ff <= '0;
      end else if (v_ff[7] && tag_ff[7].last && (mag7 > RAW_W'(peak_ff))) begin
         peak_ff <= mag7[PEAK_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (v_ff[7] && tag_ff[7].last) begin
         raw_mem[tag_ff[7].idx] <= acc_ff;
      end
      if (cmd.rd_fetch) begin
         rd_data_ff <= raw_mem[ix_ext[TAW-1:0]];
      end
   end

   // Restoring divider for |raw| * 2^15 / peak, one quotient bit per cycle.
   assign mag_rd = rd_data_ff[RAW_W-1] ? RAW_W'(-rd_data_ff) : RAW_W'(rd_data_ff);
   assign r2     = {rem_ff, 1'b0};
   assign pk_ext = (RAW_W+1)'(peak_ff);

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         sign_ff <= rd_data_ff[RAW_W-1];
         sat_ff  <= (mag_rd >= RAW_W'(peak_ff));
         rem_ff  <= mag_rd;
         quo_ff  <= '0;
         cnt_ff  <= 4'(DIV_STEPS);
      end else if (cmd.div_step) begin
         cnt_ff <= cnt_ff - 4'd1;
         if (r2 >= pk_ext) begin
            rem_ff <= RAW_W'(r2 - pk_ext);
            quo_ff <= {quo_ff[DIV_STEPS-2:0], 1'b1};
         end else begin
            rem_ff <= RAW_W'(r2);
            quo_ff <= {quo_ff[DIV_STEPS-2:0], 1'b0};
         end
      end
   end

   assign qv        = sat_ff ? 16'h8000 : {1'b0, quo_ff};
   assign rd_sample = sign_ff ? -$signed(qv)
                              : (sat_ff ? 16'sh7FFF : $signed({1'b0, quo_ff}));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_peak_ff <= peak_ff[PEAK_OUT_W-1:0];
         unique case (req_kind_type'(kind_ff))
            REQ_LOAD: begin
               rsp_sample_ff <= '0;
               rsp_status_ff <= hn_valid ? ST_OK : ST_RANGE;
            end
            REQ_GEN: begin
               rsp_sample_ff <= '0;
               rsp_status_ff <= (peak_ff == '0) ? ST_PEAK_ZERO : ST_OK;
            end
            REQ_READ: begin
               if (peak_ff == '0) begin
                  rsp_sample_ff <= '0;
                  rsp_status_ff <= ST_PEAK_ZERO;
               end else begin
                  rsp_sample_ff <= rd_sample;
                  rsp_status_ff <= ST_OK;
               end
            end
            default: begin
               rsp_sample_ff <= '0;
               rsp_status_ff <= ST_OK;
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sample_value   = rsp_sample_ff;
   assign rsp_peak_magnitude = rsp_peak_ff;
   assign rsp_status         = rsp_status_ff;

   assign stat.issue_last   = last_k && last_i;
   assign stat.pipe_empty   = (v_ff == '0);
   assign stat.idx_in_range = (ix_ext < IXW'(TABLE_SIZE));
   assign stat.div_done     = (cnt_ff == 4'd0);

endmodule

// ===== src/additive_wavetable_generator_core.sv =====
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// request   start / busy           req_type, req_harmonic_number,
//                                  req_amplitude_value, req_sample_index
// response  rsp_valid (strobe)     rsp_sample_value, rsp_peak_magnitude, rsp_status
// config    csr_valid / csr_ready  csr_data (harmonic_count)
//
// One transaction is handled at a time; busy is high from acceptance until the
// response strobe is issued. A load writes the amplitude entry and then strobes;
// a no-operation request strobes directly. A generate sums max(n, 1) harmonic
// terms for each of the TABLE_SIZE samples, n being the effective harmonic
// count: the sine/multiply-accumulate pipeline takes one harmonic term per
// cycle and is drained before the strobe. A read first wraps the index down
// by TABLE_SIZE while it exceeds the table, then fetches the sample and runs
// the 15-step divider before it strobes.
// Reset is synchronous and active high; the tables are not cleared.
// The response strobe lasts one cycle and the receiver cannot stall it.

module additive_wavetable_generator_core #(
   parameter int unsigned TABLE_SIZE    = awg_pkg::TABLE_SIZE_DEFAULT,
   parameter int unsigned MAX_HARMONICS = awg_pkg::MAX_HARMONICS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [awg_pkg::REQ_W-1:0]            req_type,
   input  logic [awg_pkg::HN_W-1:0]             req_harmonic_number,
   input  logic signed [awg_pkg::AMP_W-1:0]     req_amplitude_value,
   input  logic [awg_pkg::IDX_W-1:0]            req_sample_index,
   output logic                                 rsp_valid,
   output logic signed [awg_pkg::SAMPLE_W-1:0]  rsp_sample_value,
   output logic [awg_pkg::PEAK_OUT_W-1:0]       rsp_peak_magnitude,
   output logic [awg_pkg::STATUS_W-1:0]         rsp_status,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [awg_pkg::HN_W-1:0]             csr_data
);
   import awg_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;
   logic         csr_we;

   // The harmonic count register is only written between transactions.
   assign csr_ready = ~busy;
   assign csr_we    = csr_valid & csr_ready;

   // The controller sequences each transaction through its phases.
   awg_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_type),
      .stat     (stat),
      .busy     (busy),
      .cmd      (cmd)
   );

   // The datapath holds the amplitude and sample tables, the sine pipeline,
   // the peak tracker, the divider and the response registers.
   awg_datapath #(
      .TABLE_SIZE    (TABLE_SIZE),
      .MAX_HARMONICS (MAX_HARMONICS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .csr_we              (csr_we),
      .csr_data            (csr_data),
      .req_type            (req_type),
      .req_harmonic_number (req_harmonic_number),
      .req_amplitude_value (req_amplitude_value),
      .req_sample_index    (req_sample_index),
      .rsp_valid           (rsp_valid),
      .rsp_sample_value    (rsp_sample_value),
      .rsp_peak_magnitude  (rsp_peak_magnitude),
      .rsp_status          (rsp_status)
   );

endmodule
